@@ rtl/fwtd_pkg.sv @@
// Package for the fixed-point word to decimal text converter.
// Holds the item type passed from the front end to the back end and the ASCII codes.
// No dependencies.
package fwtd_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int INT_BITS   = 12;
  localparam int INT_DIGITS = 4;
  localparam int BCD_BITS   = 4 * INT_DIGITS;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // One classified word: sign, integer part as BCD, digit count minus one, fraction bits.
  typedef struct packed {
    logic                 neg;
    logic [BCD_BITS-1:0]  bcd;
    logic [1:0]           ndm1;
    logic [FRAC_BITS-1:0] rem;
  } fwtd_item_t;

endpackage

@@ rtl/fwtd_front.sv @@
// Front end: accepts a word, takes its magnitude and converts the integer part to BCD.
// Uses fwtd_pkg; feeds fwtd_fifo.
module fwtd_front
  import fwtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_fix_word,
  output logic              push,
  output fwtd_item_t        push_item,
  input  logic              q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'(INT_BITS - 1);

  logic [1:0]           st_r, st_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [INT_BITS-1:0]  bin_r, bin_nxt;
  logic [BCD_BITS-1:0]  bcd_r, bcd_nxt;
  logic                 neg_r;
  logic [FRAC_BITS-1:0] rem_r;
  logic [31:0]          mag;
  logic [BCD_BITS-1:0]  adj;
  logic                 accept;

  assign in_ready = (st_r == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign mag      = in_fix_word[31] ? (32'd0 - in_fix_word) : in_fix_word;

  // One double-dabble step per cycle: add three to any digit of five or more, then shift.
  always_comb begin
    adj = bcd_r;
    for (int k = 0; k < INT_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    unique case (st_r)
      F_IDLE: begin
        if (accept) begin
          st_nxt  = F_CONV;
          cnt_nxt = '0;
          bin_nxt = mag[31:FRAC_BITS];
          bcd_nxt = '0;
        end
      end
      F_CONV: begin
        bcd_nxt = {adj[BCD_BITS-2:0], bin_r[INT_BITS-1]};
        bin_nxt = {bin_r[INT_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (accept) begin
      neg_r <= in_fix_word[31];
      rem_r <= mag[FRAC_BITS-1:0];
    end
  end

  assign push           = (st_r == F_PUSH) && !q_full;
  assign push_item.neg  = neg_r;
  assign push_item.bcd  = bcd_r;
  assign push_item.rem  = rem_r;
  assign push_item.ndm1 = (bcd_r[15:12] != 4'd0) ? 2'd3 :
                          (bcd_r[11:8]  != 4'd0) ? 2'd2 :
                          (bcd_r[7:4]   != 4'd0) ? 2'd1 : 2'd0;

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_CONV) |-> (cnt_r <= LAST_STEP))
    else $error("conversion step count out of range");

  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_CONV && cnt_r == LAST_STEP) |=> (st_r == F_PUSH))
    else $error("conversion did not finish after the last step");

  a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_PUSH) |-> (bcd_r[15:12] <= 4'd2))
    else $error("integer part exceeds four digits");

endmodule

@@ rtl/fwtd_fifo.sv @@
// Two-entry queue between the front end and the back end.
// Uses fwtd_pkg for the item type.
module fwtd_fifo
  import fwtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fwtd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output fwtd_item_t q_item
);

  fwtd_item_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/fwtd_back.sv @@
// Back end: walks one classified word through sign (if negative), integer digits, point
// and fraction digits, one character per transfer, into the output register.
// Uses fwtd_pkg; reads from fwtd_fifo.
module fwtd_back
  import fwtd_pkg::*;
#(
  parameter int FRACTION_DIGITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  fwtd_item_t q_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_text_char,
  output logic       out_last_char
);

  localparam int FCW = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam logic [FCW-1:0] FRAC_LAST = FCW'(FRACTION_DIGITS - 1);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SIGN  = 3'd1;
  localparam logic [2:0] B_INT   = 3'd2;
  localparam logic [2:0] B_POINT = 3'd3;
  localparam logic [2:0] B_FRAC  = 3'd4;

  logic [2:0]           st_r, st_nxt;
  fwtd_item_t           cur_r;
  logic [1:0]           idx_r, idx_nxt;
  logic [FCW-1:0]       fcnt_r, fcnt_nxt;
  logic [FRAC_BITS-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS+3:0] prod;
  logic [7:0]           chr;
  logic                 is_last;
  logic                 emit;
  logic                 out_valid_r;
  logic [7:0]           text_r;
  logic                 last_r;

  // Remainder times ten as shift-and-add; the bits above the fraction are the digit.
  assign prod = {1'b0, rem_r, 3'b000} + {3'b000, rem_r, 1'b0};

  always_comb begin
    unique case (st_r)
      B_SIGN:  chr = CHAR_MINUS;
      B_INT:   chr = CHAR_ZERO + {4'd0, cur_r.bcd[4*idx_r +: 4]};
      B_POINT: chr = CHAR_POINT;
      B_FRAC:  chr = CHAR_ZERO + {4'd0, prod[FRAC_BITS+3:FRAC_BITS]};
      default: chr = CHAR_ZERO;
    endcase
  end

  assign is_last = (st_r == B_FRAC) && (fcnt_r == FRAC_LAST);
  assign emit    = (st_r != B_IDLE) && (!out_valid_r || out_ready);
  // The next word is taken in the same cycle as the last digit of the current one.
  assign pop     = q_valid && ((st_r == B_IDLE) || (emit && is_last));

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    fcnt_nxt = fcnt_r;
    rem_nxt  = rem_r;
    if (emit) begin
      unique case (st_r)
        B_SIGN: st_nxt = B_INT;
        B_INT: begin
          if (idx_r == 2'd0) begin
            st_nxt = B_POINT;
          end else begin
            idx_nxt = idx_r - 2'd1;
          end
        end
        B_POINT: begin
          st_nxt   = B_FRAC;
          fcnt_nxt = '0;
        end
        B_FRAC: begin
          rem_nxt  = prod[FRAC_BITS-1:0];
          fcnt_nxt = fcnt_r + FCW'(1);
          if (is_last) begin
            st_nxt = B_IDLE;
          end
        end
        default: st_nxt = B_IDLE;
      endcase
    end
    if (pop) begin
      st_nxt  = q_item.neg ? B_SIGN : B_INT;
      idx_nxt = q_item.ndm1;
      rem_nxt = q_item.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    fcnt_r <= fcnt_nxt;
    rem_r  <= rem_nxt;
    if (pop) begin
      cur_r <= q_item;
    end
    if (emit) begin
      text_r <= chr;
      last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = text_r;
  assign out_last_char = last_r;

  a_pop_point: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == B_IDLE || (st_r == B_FRAC && emit)))
    else $error("new word taken in the middle of a text");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_INT) |-> (idx_r <= cur_r.ndm1))
    else $error("integer digit index beyond digit count");

  a_sign_then_int: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && st_r == B_SIGN) |=> (st_r == B_INT && out_text_char == CHAR_MINUS))
    else $error("minus sign not followed by integer digits");

  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FRAC) |-> (fcnt_r <= FRAC_LAST))
    else $error("fraction digit count out of range");

endmodule

@@ rtl/fix_word_to_decimal_text_core.sv @@
// Fixed-point (20 fraction bits) word to decimal ASCII text, one character per transfer.
// The integer part passes a 12-step BCD conversion before the word is queued for output.
// The word rate is set by the output channel, which carries one character per transfer.
// The two-entry queue lets the next word be converted while the current one is written out.
// Reset (rst_n, synchronous, active low) empties the queue and clears the FSM states and output valid.
module fix_word_to_decimal_text_core
  import fwtd_pkg::*;
#(
  parameter int FRACTION_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_fix_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_text_char,
  output logic        out_last_char
);

  logic       push;
  fwtd_item_t push_item;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  fwtd_item_t q_item;

  fwtd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_fix_word (in_fix_word),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  fwtd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  fwtd_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

@@ tb/sv/tb_fix_word_to_decimal_text_core.sv @@
// Testbench for fix_word_to_decimal_text_core: drives fixed-point words and checks every
// ASCII character of their decimal text against an internal predictor.
// Depends on fwtd_pkg for the character codes and on the core RTL.
module tb_fix_word_to_decimal_text_core
  import fwtd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRACTION_DIGITS = 20;
  localparam int RANDOM_WORDS    = 300;
  localparam int PHASE_WORDS     = 40;
  localparam int DRAIN_CYCLES    = 60;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_fix_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_text_char;
  logic        out_last_char;

  logic [31:0] pending_words[$];
  text_char_t  expected_text[$];
  int          words_total = 0;
  int          words_accepted = 0;
  int          error_count = 0;

  logic [31:0] corner_words [23] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'h0010_0000, 32'hFFF0_0000, 32'hFFF8_0000, 32'h0008_0000,
    32'h000F_FFFF, 32'h0090_0000, 32'h00A0_0000, 32'h0630_0000, 32'h0640_0000,
    32'h3E7F_FFFF, 32'h3E80_0000, 32'h7FF0_0000, 32'h8010_0000, 32'h0001_999A,
    32'hFFFE_6666, 32'h5555_5555, 32'hAAAA_AAAA
  };

  fix_word_to_decimal_text_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_fix_word   (in_fix_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  always #4 clk = ~clk;

  // Idling pattern rotates every PHASE_WORDS (40) accepted words: none, sender only, receiver only, both.
  function automatic int sender_gap_pct();
    case ((words_accepted / PHASE_WORDS) % 4)
      1:       return 48;
      3:       return 15;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((words_accepted / PHASE_WORDS) % 4)
      2:       return 48;
      3:       return 15;
      default: return 0;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last);
    text_char_t entry;
    entry.text_char = ch;
    entry.last_char = last;
    expected_text = {expected_text, entry};
  endtask

  // Renders one word: sign, integer digits without leading zeros, point, truncated fraction.
  task automatic predict_text(input logic [31:0] word);
    logic        negative;
    logic [31:0] magnitude;
    logic [11:0] int_part;
    logic [31:0] frac_rem;
    logic [3:0]  digits [4];
    int          ndigits;
    negative  = word[31];
    magnitude = negative ? (32'd0 - word) : word;
    int_part  = magnitude[31:20];
    frac_rem  = {12'd0, magnitude[19:0]};
    ndigits   = 0;
    if (negative) push_char(CHAR_MINUS, 1'b0);
    do begin
      digits[ndigits] = 4'(int_part % 10);
      int_part = 12'(int_part / 10);
      ndigits++;
    end while (int_part != 0 && ndigits < 4);
    for (int i = ndigits - 1; i >= 0; i--) push_char(CHAR_ZERO + 8'(digits[i]), 1'b0);
    push_char(CHAR_POINT, 1'b0);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      frac_rem = frac_rem * 10;
      push_char(CHAR_ZERO + 8'(frac_rem >> 20), i == FRACTION_DIGITS - 1);
      frac_rem = frac_rem & 32'h000F_FFFF;
    end
  endtask

  // Mostly words with a chosen count of integer digits, the rest uniform over all 32 bits.
  function automatic logic [31:0] random_word();
    logic [11:0] int_part;
    logic [19:0] frac;
    logic [31:0] word;
    case ($urandom_range(0, 5))
      0:       int_part = 12'($urandom_range(0, 9));
      1:       int_part = 12'($urandom_range(10, 99));
      2:       int_part = 12'($urandom_range(100, 999));
      3:       int_part = 12'($urandom_range(1000, 2047));
      default: return $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       frac = 20'h00000;
      1:       frac = 20'hFFFFF;
      default: frac = 20'($urandom);
    endcase
    word = {int_part, frac};
    if ($urandom_range(0, 1) == 1) word = 32'd0 - word;
    return word;
  endfunction

  initial begin
    foreach (corner_words[i]) pending_words = {pending_words, corner_words[i]};
    for (int i = 0; i < RANDOM_WORDS; i++) pending_words = {pending_words, random_word()};
    words_total = pending_words.size();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (words_accepted < words_total || expected_text.size() != 0) @(posedge clk);
    // Any character that shows up after this point has no expectation and is flagged.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fix_word_to_decimal_text_core: match");
    end else begin
      $display("fix_word_to_decimal_text_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fix_word_to_decimal_text_core: mismatch");
    $finish;
  end

  // Driver: a word stays on the bus until its transfer, then the next may follow a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
        in_valid    <= 1'b1;
        in_fix_word <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every input transfer, checks on every output transfer.
  always @(posedge clk) begin
    text_char_t head;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_fix_word);
        words_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected character 0x%02h last=%0b", out_text_char, out_last_char);
        end else begin
          head = expected_text.pop_front();
          if (out_text_char !== head.text_char || out_last_char !== head.last_char) begin
            error_count++;
            if (error_count <= 10)
              $display("character: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       head.text_char, head.last_char, out_text_char, out_last_char);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

endmodule

@@ files.f @@
rtl/fwtd_pkg.sv
rtl/fwtd_front.sv
rtl/fwtd_fifo.sv
rtl/fwtd_back.sv
rtl/fix_word_to_decimal_text_core.sv
tb/sv/tb_fix_word_to_decimal_text_core.sv
